@@ src/fsktsd_pkg.sv @@
// ----------------------------------------------------------------------------
// FSK tone symbol decoder package
// Shared widths, band limits, command and status types and band helper.
// ----------------------------------------------------------------------------
package fsktsd_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CAP_W      = 16;
    localparam int PCLK_W     = 27;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int CNT_W      = $clog2(PCLK_W);

    localparam logic [PCLK_W-1:0] PCLK_RESET = PCLK_W'(18000000);

    localparam logic [PCLK_W-1:0] STX_LO = PCLK_W'(4480);
    localparam logic [PCLK_W-1:0] STX_HI = PCLK_W'(4520);
    localparam logic [PCLK_W-1:0] B0_LO  = PCLK_W'(480);
    localparam logic [PCLK_W-1:0] B0_HI  = PCLK_W'(520);
    localparam logic [PCLK_W-1:0] B1_LO  = PCLK_W'(700);
    localparam logic [PCLK_W-1:0] B1_HI  = PCLK_W'(740);
    localparam logic [PCLK_W-1:0] B2_LO  = PCLK_W'(880);
    localparam logic [PCLK_W-1:0] B2_HI  = PCLK_W'(920);
    localparam logic [PCLK_W-1:0] B3_LO  = PCLK_W'(1180);
    localparam logic [PCLK_W-1:0] B3_HI  = PCLK_W'(1220);
    localparam logic [PCLK_W-1:0] ETX_LO = PCLK_W'(4980);
    localparam logic [PCLK_W-1:0] ETX_HI = PCLK_W'(5020);
    localparam logic [PCLK_W-1:0] END_LO = PCLK_W'(5605);
    localparam logic [PCLK_W-1:0] END_HI = PCLK_W'(5645);

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [PADDR_W-1:0] ADDR_PCLK = PADDR_W'(0);

    typedef struct packed {
        logic capture;
        logic div_step;
        logic classify;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_go;
        logic out_free;
    } dpath_sts_t;

    function automatic logic in_band(input logic [PCLK_W-1:0] f,
                                     input logic [PCLK_W-1:0] lo,
                                     input logic [PCLK_W-1:0] hi);
        return (f > lo) && (f < hi);
    endfunction

endpackage

@@ src/fsktsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// FSK tone symbol decoder controller
// Sequences capture, the serial divide and the classification step.
// ----------------------------------------------------------------------------
module fsktsd_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  fsktsd_pkg::dpath_sts_t sts,
    output fsktsd_pkg::ctrl_cmd_t  cmd
);
    import fsktsd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CLASSIFY
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.capture  = 1'b0;
        cmd.div_step = 1'b0;
        cmd.classify = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid && sts.div_go)
                begin
                    state_next = ST_DIVIDE;
                    cnt_next   = '0;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PCLK_W - 1))
                begin
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                if (sts.out_free)
                begin
                    cmd.classify = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ src/fsktsd_dpath.sv @@
// ----------------------------------------------------------------------------
// FSK tone symbol decoder datapath
// Edge pairing, restoring divider, band classification and result register.
// ----------------------------------------------------------------------------
module fsktsd_dpath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [fsktsd_pkg::CAP_W-1:0]      capture_value,
    input  logic [fsktsd_pkg::PCLK_W-1:0]     pclk_hz,
    input  fsktsd_pkg::ctrl_cmd_t             cmd,
    output fsktsd_pkg::dpath_sts_t            sts,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              result_kind,
    output logic [7:0]                        data_byte
);
    import fsktsd_pkg::*;

    logic                   have_first_reg, have_first_next;
    logic [TIMER_BITS-1:0]  first_time_reg, first_time_next;
    logic [TIMER_BITS-1:0]  last_period_reg, last_period_next;
    logic                   in_frame_reg, in_frame_next;
    logic [7:0]             asm_reg, asm_next;
    logic                   shifted_reg, shifted_next;
    logic                   parity_reg, parity_next;

    logic [PCLK_W-1:0]      quo_reg, quo_next;
    logic [TIMER_BITS:0]    rem_reg, rem_next;
    logic [TIMER_BITS-1:0]  divisor_reg, divisor_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   kind_reg, kind_next;
    logic [7:0]             byte_reg, byte_next;

    logic [TIMER_BITS-1:0]  cap;
    logic [TIMER_BITS-1:0]  period;
    logic                   period_nz;
    logic [TIMER_BITS:0]    rem_sh;
    logic                   rem_ge;
    logic                   emit_data;
    logic                   emit_end;
    logic [7:0]             asm_work;

    assign cap       = capture_value[TIMER_BITS-1:0];
    assign period    = cap - first_time_reg;
    assign period_nz = (period != '0);

    assign sts.div_go   = have_first_reg && (period_nz || (last_period_reg != '0));
    assign sts.out_free = !out_valid_reg || out_ready;

    // One restoring-divide step: bring down the next dividend bit.
    assign rem_sh = {rem_reg[TIMER_BITS-1:0], quo_reg[PCLK_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, divisor_reg});

    always_comb
    begin
        have_first_next  = have_first_reg;
        first_time_next  = first_time_reg;
        last_period_next = last_period_reg;
        in_frame_next    = in_frame_reg;
        asm_next         = asm_reg;
        shifted_next     = shifted_reg;
        parity_next      = parity_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        divisor_next     = divisor_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        kind_next        = kind_reg;
        byte_next        = byte_reg;
        emit_data        = 1'b0;
        emit_end         = 1'b0;
        asm_work         = asm_reg;

        if (cmd.capture)
        begin
            if (!have_first_reg)
            begin
                have_first_next = 1'b1;
                first_time_next = cap;
            end
            else
            begin
                have_first_next = 1'b0;
                if (period_nz)
                begin
                    last_period_next = period;
                end
                quo_next     = pclk_hz;
                rem_next     = '0;
                divisor_next = period_nz ? period : last_period_reg;
            end
        end

        if (cmd.div_step)
        begin
            rem_next = rem_ge ? (rem_sh - {1'b0, divisor_reg}) : rem_sh;
            quo_next = {quo_reg[PCLK_W-2:0], rem_ge};
        end

        if (cmd.classify)
        begin
            if (in_band(quo_reg, STX_LO, STX_HI) && !in_frame_reg)
            begin
                in_frame_next = 1'b1;
            end
            else if (in_band(quo_reg, B0_LO, B0_HI))
            begin
                asm_work = asm_work | 8'h01;
            end
            else if (in_band(quo_reg, B1_LO, B1_HI))
            begin
                asm_work = asm_work | 8'h02;
            end
            else if (in_band(quo_reg, B2_LO, B2_HI))
            begin
                asm_work = asm_work | 8'h04;
            end
            else if (in_band(quo_reg, B3_LO, B3_HI))
            begin
                asm_work = asm_work | 8'h08;
            end

            if (in_band(quo_reg, ETX_LO, ETX_HI) && in_frame_reg)
            begin
                in_frame_next = 1'b0;
                parity_next   = !parity_reg;
                if (!shifted_reg)
                begin
                    asm_work     = {asm_work[3:0], 4'h0};
                    shifted_next = 1'b1;
                end
                if (parity_reg)
                begin
                    emit_data    = 1'b1;
                    byte_next    = {asm_work[3:0], asm_work[7:4]};
                    kind_next    = KIND_DATA;
                    asm_work     = 8'h00;
                    shifted_next = 1'b0;
                end
            end

            if (in_band(quo_reg, END_LO, END_HI))
            begin
                emit_end    = 1'b1;
                kind_next   = KIND_END;
                byte_next   = 8'h00;
                parity_next = 1'b0;
            end

            asm_next = asm_work;
            if (emit_data || emit_end)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_first_reg  <= 1'b0;
            first_time_reg  <= '0;
            last_period_reg <= '0;
            in_frame_reg    <= 1'b0;
            asm_reg         <= '0;
            shifted_reg     <= 1'b0;
            parity_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            have_first_reg  <= have_first_next;
            first_time_reg  <= first_time_next;
            last_period_reg <= last_period_next;
            in_frame_reg    <= in_frame_next;
            asm_reg         <= asm_next;
            shifted_reg     <= shifted_next;
            parity_reg      <= parity_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        kind_reg    <= kind_next;
        byte_reg    <= byte_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign data_byte   = byte_reg;

endmodule

@@ src/fsk_tone_symbol_decoder_core.sv @@
// ----------------------------------------------------------------------------
// FSK tone symbol decoder core
// Pairs timer captures, divides the reference clock by the period and
// decodes tone bands into data bytes and message-end markers.
// ----------------------------------------------------------------------------
// Sequence: the first capture of a pair is only recorded. The second capture
//   starts a serial restoring divide of pclk_hz by the period, or if that is
//   zero by the last nonzero one, if any; once the result register is free,
//   classification loads it if a symbol results. Captures are taken only while
//   the controller is idle, so a new pair waits until the last is classified.
// Reset: rst_n clears decoder state and out_valid; pclk_hz returns to 18000000.
// ----------------------------------------------------------------------------
module fsk_tone_symbol_decoder_core
(
    input  logic                                clk,
    input  logic                                rst_n,

    // Capture request channel.
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [fsktsd_pkg::CAP_W-1:0]        capture_value,

    // Result request channel.
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                result_kind,
    output logic [7:0]                          data_byte,

    // Register port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fsktsd_pkg::PADDR_W-1:0]      paddr,
    input  logic [fsktsd_pkg::PDATA_W-1:0]      pwdata,
    output logic [fsktsd_pkg::PDATA_W-1:0]      prdata,
    output logic                                pready
);
    import fsktsd_pkg::*;

    logic [PCLK_W-1:0]  pclk_hz_reg, pclk_hz_next;
    logic               reg_sel;
    ctrl_cmd_t          cmd;
    dpath_sts_t         sts;

    // The register file holds a single word at byte address zero. Decoding
    // uses the word address bit, so any byte lane of word zero selects it.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == ADDR_PCLK[PADDR_W-1:2]);

    always_comb
    begin
        pclk_hz_next = pclk_hz_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            pclk_hz_next = pwdata[PCLK_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel)
        begin
            prdata = {{(PDATA_W - PCLK_W){1'b0}}, pclk_hz_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pclk_hz_reg <= PCLK_RESET;
        end
        else
        begin
            pclk_hz_reg <= pclk_hz_next;
        end
    end

    // The controller owns sequencing; the datapath owns every piece of
    // decoder state and the result register that decouples the output.
    fsktsd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fsktsd_dpath u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .capture_value (capture_value),
        .pclk_hz       (pclk_hz_reg),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .data_byte     (data_byte)
    );

endmodule

@@ src/fsktsd_checker.sv @@
// ----------------------------------------------------------------------------
// FSK tone symbol decoder port checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module fsktsd_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       result_kind,
    input  logic [7:0] data_byte,
    input  logic       pready
);
    import fsktsd_pkg::*;

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A message-end marker always carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_END) |-> (data_byte == 8'h00))
        else $error("message-end marker with nonzero byte");

    // A result cannot appear right after a capture, as the divide lies between.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result appeared without a divide");

    // A result is loaded only from a non-idle controller state, never while idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result loaded while idle");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("register port stalled");

endmodule

bind fsk_tone_symbol_decoder_core fsktsd_checker u_fsktsd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .data_byte   (data_byte),
    .pready      (pready)
);

@@ tb/tb_fsk_tone_symbol_decoder_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FSK tone symbol decoder core testbench
// Feeds timer captures through the valid/ready capture channel, predicts the
// decoded bytes and message-end markers in a behavioral decoder, and checks
// every result request in order. The pclk_hz register is written and read
// back over the APB port between phases. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_fsk_tone_symbol_decoder_core;

    import fsktsd_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 4;
    // Margin for the divide and classification after the closing capture.
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 1500;
    localparam int RANDOM_ITEMS   = 1825;
    localparam int RANDOM_PHASES  = 5;
    localparam int TIMEOUT_CYCLES = 1000000;

    // Row kinds of the directed table.
    localparam logic ROW_CAPTURE = 1'b0;
    localparam logic ROW_CLOCK   = 1'b1;

    // Tone bands that the random part aims at.
    typedef enum int
    {
        TONE_STX,
        TONE_B0,
        TONE_B1,
        TONE_B2,
        TONE_B3,
        TONE_ETX,
        TONE_END
    } tone_e;

    // One decoded symbol as it leaves the result channel.
    typedef struct packed
    {
        logic       kind;
        logic [7:0] data_val;
    } decoded_t;

    localparam decoded_t NO_TYPED = '0;

    // One row of the directed table. A clock row writes pclk_hz with value;
    // a capture row sends value[15:0]. Where fixed_result is set the row's
    // expected symbol is written out by hand instead of being predicted.
    typedef struct packed
    {
        logic        row_kind;
        logic [31:0] value;
        logic        fixed_result;
        logic        want_kind;
        logic [7:0]  want_byte;
    } dir_row_t;

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic [CAP_W-1:0]    capture_value = '0;
    logic                out_valid;
    logic                out_ready     = 1'b0;
    logic                result_kind;
    logic [7:0]          data_byte;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [PADDR_W-1:0]  paddr         = '0;
    logic [PDATA_W-1:0]  pwdata        = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // ------------------------------------------------------------------------
    // Behavioral decoder state. It tracks the block's state as of the last
    // accepted capture request and the register value last written.
    // ------------------------------------------------------------------------
    logic                  pair_open   = 1'b0;
    logic [TIMER_BITS-1:0] pair_start  = '0;
    logic [16:0]           held_period = '0;   // zero means no period seen yet
    logic                  frame_open  = 1'b0;
    logic [7:0]            nibble_acc  = 8'h00;
    logic                  low_moved   = 1'b0;
    logic                  odd_etx     = 1'b0;
    logic [PCLK_W-1:0]     ref_clk_hz  = PCLK_RESET;

    // Symbols predicted but not yet seen on the result channel, oldest first.
    decoded_t decoded_expect[$];

    int  mismatch_count = 0;
    int  captures_sent  = 0;
    int  burst_left     = 0;
    bit  hold_off_req   = 1'b0;

    // Directed table. It runs at the reset clock of 18 MHz, where a period
    // of 4000 ticks is STX, 36000 is 500 Hz, 25000 is 720 Hz, 20000 is
    // 900 Hz, 15000 is 1200 Hz, 3600 is ETX and 3200 is message end.
    dir_row_t directed_rows [0:26] = '{
        //  row          value      fixed  kind       byte
        // Equal captures before any period: nothing to classify.
        '{ROW_CAPTURE, 32'd0,     1'b0, KIND_DATA, 8'h00},
        '{ROW_CAPTURE, 32'd0,     1'b0, KIND_DATA, 8'h00},
        // STX with the timer wrapping between the captures.
        '{ROW_CAPTURE, 32'd65535, 1'b0, KIND_DATA, 8'h00},
        '{ROW_CAPTURE, 32'd3999,  1'b0, KIND_DATA, 8'h00},
        // 500 Hz then 1200 Hz: first nibble becomes 9.
        '{ROW_CAPTURE, 32'd100,   1'b0, KIND_DATA, 8'h00},
        '{ROW_CAPTURE, 32'd36100, 1'b0, KIND_DATA, 8'h00},
        '{ROW_CAPTURE, 32'd0,     1'b0, KIND_DATA, 8'h00},
        '{ROW_CAPTURE, 32'd15000, 1'b0, KIND_DATA, 8'h00},
        // First ETX of the byte moves the nibble up.
        '{ROW_CAPTURE, 32'd200,   1'b0, KIND_DATA, 8'h00},
        '{ROW_CAPTURE, 32'd3800,  1'b0, KIND_DATA, 8'h00},
        // STX opens the second half.
        '{ROW_CAPTURE, 32'd1000,  1'b0, KIND_DATA, 8'h00},
        '{ROW_CAPTURE, 32'd5000,  1'b0, KIND_DATA, 8'h00},
        // Equal captures reuse the STX period while the frame is open.
        '{ROW_CAPTURE, 32'd4000,  1'b0, KIND_DATA, 8'h00},
        '{ROW_CAPTURE, 32'd4000,  1'b0, KIND_DATA, 8'h00},
        // 720 Hz and 900 Hz: second nibble becomes 6.
        '{ROW_CAPTURE, 32'd0,     1'b0, KIND_DATA, 8'h00},
        '{ROW_CAPTURE, 32'd25000, 1'b0, KIND_DATA, 8'h00},
        '{ROW_CAPTURE, 32'd30000, 1'b0, KIND_DATA, 8'h00},
        '{ROW_CAPTURE, 32'd50000, 1'b0, KIND_DATA, 8'h00},
        // Second ETX emits the byte with the first nibble low.
        '{ROW_CAPTURE, 32'd0,     1'b0, KIND_DATA, 8'h00},
        '{ROW_CAPTURE, 32'd3600,  1'b1, KIND_DATA, 8'h69},
        // ETX with no open frame is dropped.
        '{ROW_CAPTURE, 32'd0,     1'b0, KIND_DATA, 8'h00},
        '{ROW_CAPTURE, 32'd3600,  1'b0, KIND_DATA, 8'h00},
        // Message end.
        '{ROW_CAPTURE, 32'd0,     1'b0, KIND_DATA, 8'h00},
        '{ROW_CAPTURE, 32'd3200,  1'b1, KIND_END,  8'h00},
        // A zero reference clock gives frequency zero, which is no band.
        '{ROW_CLOCK,   32'd0,     1'b0, KIND_DATA, 8'h00},
        '{ROW_CAPTURE, 32'd65535, 1'b0, KIND_DATA, 8'h00},
        '{ROW_CAPTURE, 32'd4000,  1'b0, KIND_DATA, 8'h00}
    };

    fsk_tone_symbol_decoder_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .capture_value (capture_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .data_byte     (data_byte),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioral decoder
    // ------------------------------------------------------------------------

    function automatic bit strictly_between(input logic [PCLK_W-1:0] freq,
                                            input logic [PCLK_W-1:0] lo,
                                            input logic [PCLK_W-1:0] hi);
        return (freq > lo) && (freq < hi);
    endfunction

    // Advances the decoder by one capture. Returns 1 when the capture
    // produces a symbol, which is then given in kind and data_val.
    function automatic bit decode_capture(input  logic [CAP_W-1:0] cap,
                                          output logic             kind,
                                          output logic [7:0]       data_val);
        logic [TIMER_BITS-1:0] span;
        logic [PCLK_W-1:0]     freq;
        bit                    emits;
        emits    = 1'b0;
        kind     = KIND_DATA;
        data_val = 8'h00;

        // The first capture of a pair only records the edge time.
        if (!pair_open)
        begin
            pair_open  = 1'b1;
            pair_start = cap[TIMER_BITS-1:0];
            return 1'b0;
        end
        pair_open = 1'b0;

        // Modulo subtraction handles timer wrap. A zero span keeps the old
        // period, and with no period at all the pair is simply dropped.
        span = cap[TIMER_BITS-1:0] - pair_start;
        if (span != 0)
            held_period = {1'b0, span};
        if (held_period == 0)
            return 1'b0;
        freq = ref_clk_hz / held_period;

        // STX has priority but only when no frame is open; the data bands
        // collect bits whether a frame is open or not.
        if (strictly_between(freq, STX_LO, STX_HI) && !frame_open)
            frame_open = 1'b1;
        else if (strictly_between(freq, B0_LO, B0_HI))
            nibble_acc = nibble_acc | 8'h01;
        else if (strictly_between(freq, B1_LO, B1_HI))
            nibble_acc = nibble_acc | 8'h02;
        else if (strictly_between(freq, B2_LO, B2_HI))
            nibble_acc = nibble_acc | 8'h04;
        else if (strictly_between(freq, B3_LO, B3_HI))
            nibble_acc = nibble_acc | 8'h08;

        // ETX closes the frame. The first one of a byte moves the nibble
        // up, the second swaps the halves and hands the byte out.
        if (strictly_between(freq, ETX_LO, ETX_HI) && frame_open)
        begin
            frame_open = 1'b0;
            odd_etx    = !odd_etx;
            if (!low_moved)
            begin
                nibble_acc = nibble_acc << 4;
                low_moved  = 1'b1;
            end
            if (!odd_etx)
            begin
                emits      = 1'b1;
                kind       = KIND_DATA;
                data_val   = {nibble_acc[3:0], nibble_acc[7:4]};
                nibble_acc = 8'h00;
                low_moved  = 1'b0;
            end
        end

        // Message end only clears the ETX parity; the frame and the
        // partial byte survive it.
        if (strictly_between(freq, END_LO, END_HI))
        begin
            emits    = 1'b1;
            kind     = KIND_END;
            data_val = 8'h00;
            odd_etx  = 1'b0;
        end
        return emits;
    endfunction

    function automatic int band_limit(input tone_e tone, input bit upper);
        case (tone)
            TONE_STX: return upper ? int'(STX_HI) : int'(STX_LO);
            TONE_B0:  return upper ? int'(B0_HI)  : int'(B0_LO);
            TONE_B1:  return upper ? int'(B1_HI)  : int'(B1_LO);
            TONE_B2:  return upper ? int'(B2_HI)  : int'(B2_LO);
            TONE_B3:  return upper ? int'(B3_HI)  : int'(B3_LO);
            TONE_ETX: return upper ? int'(ETX_HI) : int'(ETX_LO);
            default:  return upper ? int'(END_HI) : int'(END_LO);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Capture request side
    // ------------------------------------------------------------------------

    // Offers one capture request and waits for it to be taken. The sender
    // works in bursts; a new burst may start after a random gap. Once the
    // request is taken the decoder is advanced, and either its symbol or
    // the hand-written one is queued.
    task automatic send_capture(input logic [CAP_W-1:0] cap,
                                input bit               fixed_result,
                                input decoded_t         written);
        int         gap;
        bit         emits;
        logic       hit_kind;
        logic [7:0] hit_byte;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // Now and then a long burst with no gaps at all.
            burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(50, 150))
                                                     : int'($urandom_range(1, 24));
        end
        burst_left--;
        in_valid      <= 1'b1;
        capture_value <= cap;
        do
            @(posedge clk);
        while (!in_ready);
        captures_sent++;
        emits = decode_capture(cap, hit_kind, hit_byte);
        if (fixed_result)
            decoded_expect.push_back(written);
        else if (emits)
            decoded_expect.push_back(decoded_t'({hit_kind, hit_byte}));
    endtask

    // Sends one pair of captures whose period lands in or near a band at
    // the current reference clock. A pair left open by noise is closed
    // first so that the tone pairs up as intended.
    task automatic send_tone(input tone_e tone);
        int               lo;
        int               hi;
        int               period;
        int               span;
        logic [CAP_W-1:0] start;
        lo = band_limit(tone, 1'b0);
        hi = band_limit(tone, 1'b1);
        if (pair_open)
            send_capture(CAP_W'($urandom), 1'b0, NO_TYPED);
        if ($urandom_range(0, 7) == 0)
        begin
            // Right on a band edge, which the strict compare must reject
            // when the quotient hits the limit exactly.
            period = int'(ref_clk_hz) / (($urandom_range(0, 1) == 1) ? lo : hi);
        end
        else
        begin
            // Rounded center period with a little jitter, sometimes more.
            period = (int'(ref_clk_hz) + (lo + hi) / 4) / ((lo + hi) / 2);
            span   = ($urandom_range(0, 3) == 0) ? period / 40 : period / 400;
            period = period + int'($urandom_range(0, 2 * span)) - span;
        end
        // Tones the timer cannot measure at this clock turn into noise.
        if (period < 1 || period > 65535)
            period = int'($urandom_range(1, 65535));
        start = CAP_W'($urandom);
        send_capture(start, 1'b0, NO_TYPED);
        send_capture(start + CAP_W'(period), 1'b0, NO_TYPED);
    endtask

    // One frame: STX, a few data tones, ETX. Two frames make a byte.
    task automatic send_frame();
        int n_data;
        send_tone(TONE_STX);
        if ($urandom_range(0, 5) == 0)
        begin
            send_tone(TONE_B3);
            send_tone(TONE_B2);
            send_tone(TONE_B1);
            send_tone(TONE_B0);
        end
        else
        begin
            n_data = $urandom_range(0, 4);
            repeat (n_data) send_tone(tone_e'($urandom_range(TONE_B0, TONE_B3)));
        end
        send_tone(TONE_ETX);
    endtask

    // Mostly well-formed frames and message ends; the rest is stray tones,
    // random pairs, equal captures and lone edges that break the pairing.
    task automatic send_random_step();
        int               pick;
        logic [CAP_W-1:0] cap;
        pick = $urandom_range(0, 99);
        cap  = CAP_W'($urandom);
        if (pick < 60)
            send_frame();
        else if (pick < 68)
            send_tone(TONE_END);
        else if (pick < 76)
            send_tone(tone_e'($urandom_range(TONE_STX, TONE_END)));
        else if (pick < 86)
        begin
            send_capture(cap, 1'b0, NO_TYPED);
            send_capture(CAP_W'($urandom), 1'b0, NO_TYPED);
        end
        else if (pick < 94)
        begin
            send_capture(cap, 1'b0, NO_TYPED);
            send_capture(cap, 1'b0, NO_TYPED);
        end
        else
            send_capture(cap, 1'b0, NO_TYPED);
    endtask

    // Stops offering requests and waits for every predicted symbol, then
    // for the divider latency, since a pair that yields nothing may still
    // be in the divider.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (decoded_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------------

    // Writes pclk_hz with a setup and an access phase, then reads it back.
    task automatic write_pclk(input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] read_val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PCLK;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        ref_clk_hz = value[PCLK_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        read_val = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (read_val !== PDATA_W'(ref_clk_hz))
        begin
            $display("%0t: pclk_hz read back: expected %0d, actual %0d",
                     $time, ref_clk_hz, read_val);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result request side
    // ------------------------------------------------------------------------

    // The receiver switches between always ready, coin-flip ready and
    // mostly stalled, each for a random stretch. On request it holds off
    // completely for a long count so that the block backs up and stalls
    // the capture channel.
    initial
    begin : result_sink
        int hold_left;
        int mode;
        int mode_left;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
                out_ready   <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= $urandom_range(0, 1);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Every accepted result request is matched against the oldest
    // predicted symbol, field by field.
    always @(posedge clk)
    begin : result_check
        decoded_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_expect.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual kind %0b byte %02h",
                         $time, result_kind, data_byte);
                mismatch_count++;
            end
            else
            begin
                want = decoded_expect.pop_front();
                if (result_kind !== want.kind)
                begin
                    $display("%0t: result_kind: expected %0b, actual %0b",
                             $time, want.kind, result_kind);
                    mismatch_count++;
                end
                if (data_byte !== want.data_val)
                begin
                    $display("%0t: data_byte: expected %02h, actual %02h",
                             $time, want.data_val, data_byte);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_flow
        int                 phase_end;
        logic [PDATA_W-1:0] clk_setting;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed table runs first on the reset value of pclk_hz.
        for (int row = 0; row < $size(directed_rows); row++)
        begin
            if (directed_rows[row].row_kind == ROW_CLOCK)
            begin
                wait_until_drained();
                write_pclk(directed_rows[row].value);
            end
            else
            begin
                send_capture(directed_rows[row].value[CAP_W-1:0],
                             directed_rows[row].fixed_result,
                             decoded_t'({directed_rows[row].want_kind,
                                         directed_rows[row].want_byte}));
            end
        end

        // Random phases, each at its own reference clock: nominal, both
        // ends of the range and two random settings. Each phase starts with
        // the sender paused until all symbols are out.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       clk_setting = PDATA_W'(18000000);
                1:       clk_setting = PDATA_W'(1000000);
                2:       clk_setting = PDATA_W'(72000000);
                default: clk_setting = PDATA_W'($urandom_range(1000000, 72000000));
            endcase
            wait_until_drained();
            write_pclk(clk_setting);
            // At the nominal clock every band is reachable, so results come
            // often enough to back the block up during the long hold-off.
            if (phase == 0)
                hold_off_req = 1'b1;
            phase_end = captures_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (captures_sent < phase_end)
                send_random_step();
        end

        wait_until_drained();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
src/fsktsd_pkg.sv
src/fsktsd_ctrl.sv
src/fsktsd_dpath.sv
src/fsk_tone_symbol_decoder_core.sv
src/fsktsd_checker.sv
tb/tb_fsk_tone_symbol_decoder_core.sv
